/* rtl/core/rgb_to_hsv_integer_macros.svh */
// Assertion macros shared by the rgb_to_hsv_integer RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef RGB_TO_HSV_INTEGER_MACROS_SVH
`define RGB_TO_HSV_INTEGER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RTH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// antecedent implies consequent in the next cycle
`define RTH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/core/rth_pkg.sv */
// Types and constants for the rgb_to_hsv_integer pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package rth_pkg;

  localparam int unsigned DIV_STAGES = 8;  // one quotient bit per stage

  localparam logic [10:0] HUE_BASE_GREEN = 11'd510;
  localparam logic [10:0] HUE_BASE_BLUE  = 11'd1020;
  localparam logic [10:0] HUE_WRAP       = 11'd1530;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } rth_sector_t;

  // one restoring-division lane: partial remainder, dividend/quotient shifter, divisor
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] lq;
    logic [7:0] dvs;
  } rth_div_t;

  typedef struct packed {
    rth_sector_t sector;
    logic        neg;     // channel difference below zero
    logic        grey;    // chroma is zero
    logic        black;   // max is zero
    logic [7:0]  val;
  } rth_side_t;

  typedef struct packed {
    rth_div_t  sat;
    rth_div_t  hue;
    rth_side_t side;
  } rth_pipe_t;

endpackage

`default_nettype wire

/* rtl/core/rth_front.sv */
// Front end: max/min/sector selection, then scaling by 255 into divider lanes.
// Depends on rth_pkg.
`default_nettype none

module rth_front import rth_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output rth_pipe_t      dn_data
);

  // stage A registers
  logic        a_valid_r;
  logic [7:0]  a_max_r, a_chroma_r, a_diff_r;
  rth_side_t   a_side_r;
  logic [7:0]  a_max_nxt, a_chroma_nxt, a_diff_nxt, a_min;
  rth_side_t   a_side_nxt;
  logic        a_ready;

  // stage B registers
  logic        b_valid_r;
  rth_pipe_t   b_data_r;
  rth_pipe_t   b_data_nxt;
  logic [15:0] sat_num, hue_num;

  assign a_ready  = !a_valid_r || !b_valid_r || dn_ready;
  assign up_ready = !a_valid_r || a_ready && (!b_valid_r || dn_ready);

  always_comb begin
    a_side_nxt = '0;
    a_diff_nxt = '0;
    if (red >= green && red >= blue) begin
      a_side_nxt.sector = SEC_RED;
      a_max_nxt         = red;
      a_side_nxt.neg    = blue > green;
      a_diff_nxt        = (blue > green) ? blue - green : green - blue;
    end else if (green >= blue) begin
      a_side_nxt.sector = SEC_GREEN;
      a_max_nxt         = green;
      a_side_nxt.neg    = red > blue;
      a_diff_nxt        = (red > blue) ? red - blue : blue - red;
    end else begin
      a_side_nxt.sector = SEC_BLUE;
      a_max_nxt         = blue;
      a_side_nxt.neg    = green > red;
      a_diff_nxt        = (green > red) ? green - red : red - green;
    end
    a_min = red;
    if (green < a_min) a_min = green;
    if (blue < a_min) a_min = blue;
    a_chroma_nxt     = a_max_nxt - a_min;
    a_side_nxt.grey  = (a_chroma_nxt == 8'd0);
    a_side_nxt.black = (a_max_nxt == 8'd0);
    a_side_nxt.val   = a_max_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (up_ready) begin
      a_valid_r <= up_valid;
    end
    if (up_ready) begin
      a_max_r    <= a_max_nxt;
      a_chroma_r <= a_chroma_nxt;
      a_diff_r   <= a_diff_nxt;
      a_side_r   <= a_side_nxt;
    end
  end

  // x * 255 = (x << 8) - x; quotient fits 8 bits since the dividend is below 256 * divisor
  always_comb begin
    sat_num = {a_chroma_r, 8'd0} - {8'd0, a_chroma_r};
    hue_num = {a_diff_r, 8'd0} - {8'd0, a_diff_r};
    b_data_nxt.sat.rem = sat_num[15:8];
    b_data_nxt.sat.lq  = sat_num[7:0];
    b_data_nxt.sat.dvs = a_max_r;
    b_data_nxt.hue.rem = hue_num[15:8];
    b_data_nxt.hue.lq  = hue_num[7:0];
    b_data_nxt.hue.dvs = a_chroma_r;
    b_data_nxt.side    = a_side_r;
  end

  logic b_load;
  assign b_load = !b_valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_load) begin
      b_valid_r <= a_valid_r;
    end
    if (b_load) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_data  = b_data_r;

endmodule

`default_nettype wire

/* rtl/core/rth_div_stage.sv */
// One restoring-division step for both lanes (saturation and hue), registered.
// Depends on rth_pkg and rgb_to_hsv_integer_macros.svh.
`default_nettype none

`include "rgb_to_hsv_integer_macros.svh"

module rth_div_stage import rth_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire rth_pipe_t up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output rth_pipe_t      dn_data
);

  logic      valid_r;
  rth_pipe_t data_r;
  rth_pipe_t data_nxt;

  function automatic rth_div_t div_step(input rth_div_t d);
    logic [8:0] trial;
    logic       take;
    rth_div_t   o;
    trial = {d.rem, d.lq[7]};
    take  = (trial >= {1'b0, d.dvs});
    o.dvs = d.dvs;
    o.lq  = {d.lq[6:0], take};
    o.rem = take ? 8'(trial - {1'b0, d.dvs}) : trial[7:0];
    return o;
  endfunction

  always_comb begin
    data_nxt      = up_data;
    data_nxt.sat  = div_step(up_data.sat);
    data_nxt.hue  = div_step(up_data.hue);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // partial remainder always stays below a nonzero divisor
  `RTH_ASSERT_IMPL(a_hue_rem_bound, valid_r && !data_r.side.grey, data_r.hue.rem < data_r.hue.dvs)
  `RTH_ASSERT_IMPL(a_sat_rem_bound, valid_r && !data_r.side.black, data_r.sat.rem < data_r.sat.dvs)

endmodule

`default_nettype wire

/* rtl/core/rth_back.sv */
// Back end: hue assembly from sector, sign and quotient; output register.
// Depends on rth_pkg and rgb_to_hsv_integer_macros.svh.
`default_nettype none

`include "rgb_to_hsv_integer_macros.svh"

module rth_back import rth_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire rth_pipe_t up_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [10:0]    out_hue,
  output logic [7:0]     out_saturation,
  output logic [7:0]     out_brightness
);

  logic        valid_r;
  logic [10:0] hue_r, hue_nxt;
  logic [7:0]  sat_r, sat_nxt;
  logic [7:0]  val_r;
  logic [10:0] q;

  assign q = {3'd0, up_data.hue.lq};

  always_comb begin
    case (up_data.side.sector)
      SEC_RED: begin
        // negative offset wraps around; a zero quotient stays at zero
        if (up_data.side.neg && q != 11'd0) hue_nxt = HUE_WRAP - q;
        else hue_nxt = q;
      end
      SEC_GREEN: begin
        hue_nxt = up_data.side.neg ? HUE_BASE_GREEN - q : HUE_BASE_GREEN + q;
      end
      SEC_BLUE: begin
        hue_nxt = up_data.side.neg ? HUE_BASE_BLUE - q : HUE_BASE_BLUE + q;
      end
      default: begin
        hue_nxt = '0;
      end
    endcase
    if (up_data.side.grey) hue_nxt = '0;
    sat_nxt = up_data.side.black ? 8'd0 : up_data.sat.lq;
  end

  assign up_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= up_data.side.val;
    end
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = val_r;

  `RTH_ASSERT_IMPL(a_hue_range, valid_r, hue_r < HUE_WRAP)
  `RTH_ASSERT_IMPL(a_black_zero, valid_r && val_r == 8'd0, hue_r == 11'd0 && sat_r == 8'd0)

endmodule

`default_nettype wire

/* rtl/core/rgb_to_hsv_integer.sv */
// Pipeline: 2 front, 8 divide and 1 output stage between input accept and out_valid.
// Throughput: one item per cycle; each stage has its own valid bit and fills bubbles,
// so the pipeline halts only when every stage holds an item and out_ready is low.
// Reset: synchronous active-low rst_n clears all valid bits; data registers are not reset.
// Top level of rgb_to_hsv_integer; instantiates rth_front, rth_div_stage, rth_back.
`default_nettype none

`include "rgb_to_hsv_integer_macros.svh"

module rgb_to_hsv_integer import rth_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [10:0]     out_hue,
  output logic [7:0]      out_saturation,
  output logic [7:0]      out_brightness
);

  logic      vld [DIV_STAGES+1];
  logic      rdy [DIV_STAGES+1];
  rth_pipe_t dat [DIV_STAGES+1];

  rth_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0]),
    .dn_data  (dat[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    rth_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_data  (dat[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_data  (dat[i+1])
    );
  end

  rth_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (vld[DIV_STAGES]),
    .up_ready       (rdy[DIV_STAGES]),
    .up_data        (dat[DIV_STAGES]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  // input can only be blocked when the whole pipe is backed up behind the output
  `RTH_ASSERT_IMPL(a_backpressure, !in_ready, out_valid && !out_ready)

endmodule

`default_nettype wire

/* tb/rgb_to_hsv_integer_test.sv */
// Self-checking testbench for rgb_to_hsv_integer: directed and random pixels,
// with bursty input, a stalling output and a scoreboard that predicts HSV.
// Depends only on the rgb_to_hsv_integer RTL and its package.
`timescale 1ns / 100ps

module rgb_to_hsv_integer_test;

  localparam int HUE_STEP   = 255;
  localparam int BASE_GREEN = 510;
  localparam int BASE_BLUE  = 1020;
  localparam int HUE_RANGE  = 1530;
  localparam int RANDOM_PIXELS = 800;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic [10:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } hsv_t;

  class hsv_scoreboard;
    hsv_t expected_q[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    function hsv_t convert(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int   rr, gg, bb, mx, mn, chroma, h;
      hsv_t res;
      rr = int'(r);
      gg = int'(g);
      bb = int'(b);
      mx = rr;
      mn = rr;
      if (gg > mx) mx = gg;
      if (bb > mx) mx = bb;
      if (gg < mn) mn = gg;
      if (bb < mn) mn = bb;
      chroma = mx - mn;
      h = 0;
      res.sat = '0;
      if (mx != 0) begin
        res.sat = 8'((chroma * HUE_STEP) / mx);
        // grey pixels keep hue at zero; SV division truncates toward zero like the spec
        if (chroma != 0) begin
          if (rr == mx) h = ((gg - bb) * HUE_STEP) / chroma;
          else if (gg == mx) h = BASE_GREEN + ((bb - rr) * HUE_STEP) / chroma;
          else h = BASE_BLUE + ((rr - gg) * HUE_STEP) / chroma;
          if (h < 0) h += HUE_RANGE;
        end
      end
      res.hue = 11'(h);
      res.val = 8'(mx);
      return res;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      expected_q.push_back(convert(r, g, b));
    endfunction

    function void check_result(logic [10:0] hue, logic [7:0] sat, logic [7:0] val);
      hsv_t exp_hsv;
      if (expected_q.size() == 0) begin
        $error("unexpected result: hue=%0d saturation=%0d brightness=%0d", hue, sat, val);
        errors++;
        return;
      end
      exp_hsv = expected_q.pop_front();
      if (hue !== exp_hsv.hue) begin
        $error("hue: expected %0d, got %0d", exp_hsv.hue, hue);
        errors++;
      end
      if (sat !== exp_hsv.sat) begin
        $error("saturation: expected %0d, got %0d", exp_hsv.sat, sat);
        errors++;
      end
      if (val !== exp_hsv.val) begin
        $error("brightness: expected %0d, got %0d", exp_hsv.val, val);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag_leftovers();
      if (expected_q.size() != 0) begin
        $error("%0d results never arrived", expected_q.size());
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] out_hue;
  logic [7:0]  out_saturation;
  logic [7:0]  out_brightness;

  hsv_scoreboard sb;
  bit hold_req = 1'b0;
  int burst_left = 0;

  rgb_to_hsv_integer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_red, in_green, in_blue);
      if (out_valid && out_ready) sb.check_result(out_hue, out_saturation, out_brightness);
    end
  end

  // output side: changing stall patterns, plus a long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  task automatic offer_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_random_pixel();
    logic [7:0] px[3];
    int base, lead;
    case ($urandom_range(0, 5))
      0, 1: begin
        foreach (px[i]) px[i] = 8'($urandom_range(0, 255));
      end
      2: begin
        // near grey: tiny chroma stresses the divider
        base = $urandom_range(0, 255);
        foreach (px[i]) begin
          px[i] = 8'(base + $urandom_range(0, 6) - 3 < 0 ? 0 :
                     base + $urandom_range(0, 3) > 255 ? 255 : base);
          if ($urandom_range(0, 1) == 1 && px[i] < 255) px[i] = px[i] + 8'($urandom_range(0, 2));
        end
      end
      3: begin
        // two channels tie for largest
        base = $urandom_range(0, 255);
        lead = $urandom_range(0, 2);
        foreach (px[i]) px[i] = 8'(base);
        px[lead] = 8'($urandom_range(0, base));
      end
      4: begin
        foreach (px[i]) begin
          case ($urandom_range(0, 3))
            0: px[i] = 8'd0;
            1: px[i] = 8'd1;
            2: px[i] = 8'd254;
            default: px[i] = 8'd255;
          endcase
        end
      end
      default: begin
        foreach (px[i]) px[i] = 8'($urandom_range(0, 255));
        px[$urandom_range(0, 2)] = 8'd0;
      end
    endcase
    offer_pixel(px[0], px[1], px[2]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int waited;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: black, grey, primaries, ties, hue wrap, sector edges
    offer_pixel(8'd0,   8'd0,   8'd0);
    offer_pixel(8'd255, 8'd255, 8'd255);
    offer_pixel(8'd128, 8'd128, 8'd128);
    offer_pixel(8'd1,   8'd1,   8'd1);
    offer_pixel(8'd255, 8'd0,   8'd0);
    offer_pixel(8'd0,   8'd255, 8'd0);
    offer_pixel(8'd0,   8'd0,   8'd255);
    offer_pixel(8'd255, 8'd255, 8'd0);
    offer_pixel(8'd255, 8'd0,   8'd255);
    offer_pixel(8'd0,   8'd255, 8'd255);
    offer_pixel(8'd255, 8'd0,   8'd1);
    offer_pixel(8'd1,   8'd0,   8'd0);
    offer_pixel(8'd0,   8'd0,   8'd1);
    offer_pixel(8'd255, 8'd254, 8'd0);
    offer_pixel(8'd0,   8'd255, 8'd254);
    offer_pixel(8'd254, 8'd0,   8'd255);
    offer_pixel(8'd200, 8'd100, 8'd50);
    offer_pixel(8'd10,  8'd20,  8'd30);
    offer_pixel(8'd255, 8'd255, 8'd254);
    offer_pixel(8'd1,   8'd1,   8'd0);
    offer_pixel(8'd0,   8'd1,   8'd1);
    offer_pixel(8'd254, 8'd255, 8'd0);
    drain_results();

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n == 200 || n == 550) begin
        // stall the output long enough to back up the whole pipeline
        hold_req = 1'b1;
        burst_left = 80;
      end
      if (n == 400) drain_results();
      offer_random_pixel();
    end

    in_valid <= 1'b0;
    waited = 0;
    // step past the last accept edge so the final item is already noted
    do begin
      @(posedge clk);
      waited++;
    end while (sb.pending() != 0 && waited < 20000);
    repeat (30) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
